[sv/c3q_pkg.sv]
// Package for the 3x3 int8 convolution block: sizes, operation and register codes, FSM type.
// No dependencies.
package c3q_pkg;
   localparam int MaxWidth    = 512;
   localparam int KernelSize  = 3;
   localparam int InChannels  = 3;
   localparam int OutChannels = 16;
   localparam int Lanes       = 4;
   localparam int Groups      = OutChannels / Lanes;
   localparam int WeightCount = OutChannels * InChannels * KernelSize * KernelSize;
   localparam int Taps        = InChannels * KernelSize * KernelSize;
   localparam int PixBits     = 8 * InChannels;
   localparam int ColBits     = $clog2(MaxWidth);
   localparam int LineDepth   = 2 * MaxWidth;
   localparam int LineAddrBits = $clog2(LineDepth);
   localparam int WAddrBits   = $clog2(WeightCount);

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_PIXEL  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_MULT   = 3'd2,
      REG_SHIFT  = 3'd3,
      REG_LEAKY  = 3'd4
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_WIN, ST_TAP, ST_DRAIN, ST_LEAK, ST_MUL,
      ST_MULH, ST_RND, ST_OUT
   } state_type;
endpackage

[sv/c3q_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module c3q_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/conv3x3_int8_requant_leaky.sv]
// Top level of the 3x3 int8 convolution; uses c3q_pkg and c3q_ram.
// Line store and weight table are RAMs; window and bias sit in registers.
//
// Weight and bias words are written while the block stays in ST_IDLE. A pixel
// word reads its column of the line store in ST_RD0 and ST_RD1, updates the
// window and the store, and, once a full window exists, computes the 16 output
// channels one at a time on a single multiply-accumulate unit that walks the
// weight RAM. Each channel goes through its 27 taps, a drain step, activation,
// the low and high multiply halves and rounding. req_ready stays low from
// accept through ST_RD0, ST_RD1 and ST_WIN for a pixel without a full window,
// and also through the channel steps and the ST_OUT states for one with it,
// longer only if a finished word is still waiting. Each finished group of four
// channels goes to a one-word output register; the block keeps computing the
// next group while that word waits. No clearing pass after reset.
module conv3x3_int8_requant_leaky
   import c3q_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_table_index,
   input  logic signed [31:0] req_table_value,
   input  logic signed [7:0]  req_pixel_ch0,
   input  logic signed [7:0]  req_pixel_ch1,
   input  logic signed [7:0]  req_pixel_ch2,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_packed_word,
   output logic [1:0]  rsp_channel_group,
   output logic        rsp_last_of_position,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   // configuration
   logic [9:0]  width_ff;
   logic [15:0] height_ff;
   logic signed [31:0] mult_ff;
   logic [5:0]  shift_ff;
   logic        leaky_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd64;
         height_ff <= 16'd64;
         mult_ff   <= 32'sd1;
         shift_ff  <= 6'd0;
         leaky_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data[9:0];
            REG_HEIGHT: height_ff <= csr_data[15:0];
            REG_MULT:   mult_ff   <= csr_data;
            REG_SHIFT:  shift_ff  <= csr_data[5:0];
            REG_LEAKY:  leaky_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // state
   state_type state_ff, state_in;
   logic [ColBits-1:0] col_ff;
   logic [15:0] row_ff;
   logic [PixBits-1:0] win_ff [KernelSize][KernelSize];
   logic signed [31:0] bias_ff [OutChannels];
   logic [PixBits-1:0] pix_ff, top_ff;
   logic last_frame_ff;
   logic [3:0] oc_ff;
   logic [4:0] tap_ff;
   logic signed [43:0] acc_ff;
   logic signed [43:0] act_ff;
   logic signed [63:0] prod_lo_ff, prod_ff;
   logic [7:0] lane_ff [Lanes];
   logic [31:0] out_word_ff;
   logic [1:0]  out_group_ff;
   logic        out_lastp_ff, out_lastf_ff, out_valid_ff;

   // memories
   logic line_we;
   logic [LineAddrBits-1:0] line_wa, line_ra;
   logic [PixBits-1:0] line_wd, line_rd;
   logic w_we;
   logic [WAddrBits-1:0] w_wa, w_ra;
   logic [7:0] w_rd;

   c3q_ram #(.Width(PixBits), .Depth(LineDepth)) u_line (
      .clock(clock), .wr_en(line_we), .wr_addr(line_wa), .wr_data(line_wd),
      .rd_addr(line_ra), .rd_data(line_rd));
   c3q_ram #(.Width(8), .Depth(WeightCount)) u_wt (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(req_table_value[7:0]),
      .rd_addr(w_ra), .rd_data(w_rd));

   logic accept;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // geometry
   logic [10:0] w_eff;
   logic col_last, row_last, full_win;
   assign w_eff    = (width_ff > 10'(MaxWidth)) ? 11'(MaxWidth) : {1'b0, width_ff};
   assign col_last = ({2'b0, col_ff} + 11'd1) >= w_eff;
   assign row_last = ({1'b0, row_ff} + 17'd1) >= {1'b0, height_ff};
   assign full_win = (col_ff >= ColBits'(2)) && (row_ff >= 16'd2);

   assign w_we  = accept && (req_operation == OP_WEIGHT) &&
                  (req_table_index < 9'(WeightCount));
   assign w_wa  = req_table_index;

   // tap address decomposition: tap = ic*9 + ky*3 + kx
   logic [1:0] t_ic, t_ky, t_kx;
   always_comb begin
      logic [4:0] r;
      r    = tap_ff;
      t_ic = (r >= 5'd18) ? 2'd2 : (r >= 5'd9) ? 2'd1 : 2'd0;
      r    = r - 5'(9 * t_ic);
      t_ky = (r >= 5'd6) ? 2'd2 : (r >= 5'd3) ? 2'd1 : 2'd0;
      t_kx = 2'(r - 5'(3 * t_ky));
   end
   assign w_ra = WAddrBits'(oc_ff) * WAddrBits'(Taps) + WAddrBits'(tap_ff);

   // line store addressing: row 0 at col, row 1 at MaxWidth + col
   always_comb begin
      line_we = 1'b0;
      line_wa = {1'b0, col_ff};
      line_wd = pix_ff;
      line_ra = {1'b0, col_ff};
      if (state_ff == ST_RD0) line_ra = {1'b1, col_ff};
      if (state_ff == ST_RD1) begin
         line_we = 1'b1;          // row 0 takes old row 1
         line_wd = line_rd;
      end
      if (state_ff == ST_WIN) begin
         line_we = 1'b1;
         line_wa = {1'b1, col_ff};
         line_wd = pix_ff;
      end
   end

   // tap pixel (tap indices registered to align with the registered weight read)
   logic [1:0] d_ic, d_ky, d_kx;
   logic tap_v_ff;
   logic signed [7:0] tap_pix;
   logic [PixBits-1:0] tp;
   always_ff @(posedge clock) begin
      d_ic <= t_ic; d_ky <= t_ky; d_kx <= t_kx;
   end
   assign tp      = win_ff[d_ky][d_kx];
   assign tap_pix = tp[8*d_ic +: 8];

   // requant helpers
   logic signed [47:0] leak_x;
   logic [47:0] leak_mag;
   logic signed [43:0] leak_v;
   assign leak_x   = 48'(acc_ff) * 48'sd13;
   assign leak_mag = (48'd0 - 48'(leak_x)) + 48'd64;
   assign leak_v   = -44'($signed({7'd0, leak_mag[47:7]}));

   // one shared multiplier: low 22 bits of the activation, then the high 22
   logic signed [54:0] mul_part;
   assign mul_part = (state_ff == ST_MULH) ? $signed(act_ff[43:22]) * mult_ff
                                           : $signed({1'b0, act_ff[21:0]}) * mult_ff;

   logic neg_p;
   logic [63:0] mag_p, rnd_p;
   logic signed [63:0] rv;
   logic [7:0] sat;
   assign neg_p = prod_ff[63];
   assign mag_p = neg_p ? (64'd0 - 64'(prod_ff)) : 64'(prod_ff);
   always_comb begin
      rnd_p = (shift_ff == 6'd0) ? mag_p :
              ((mag_p + (64'd1 << (shift_ff - 6'd1))) >> shift_ff);
      rv    = neg_p ? -$signed(rnd_p) : $signed(rnd_p);
      if (rv > 64'sd127)       sat = 8'sd127;
      else if (rv < -64'sd128) sat = 8'h80;
      else                     sat = rv[7:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && req_operation == OP_PIXEL) state_in = ST_RD0;
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_WIN;
         ST_WIN:   state_in = full_win ? ST_TAP : ST_IDLE;
         ST_TAP:   if (tap_ff == 5'(Taps - 1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_LEAK;
         ST_LEAK:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_MULH;
         ST_MULH:  state_in = ST_RND;
         ST_RND:   state_in = (oc_ff[1:0] == 2'(Lanes - 1)) ? ST_OUT : ST_TAP;
         ST_OUT:   if (!out_valid_ff || rsp_ready)
                      state_in = (oc_ff == 4'(OutChannels - 1)) ? ST_IDLE : ST_TAP;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
         tap_v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_v_ff <= (state_ff == ST_TAP);
         // hold a waiting word, load a new one when leaving ST_OUT
         out_valid_ff <= (state_ff == ST_OUT) || (out_valid_ff && !rsp_ready);
         if (state_ff == ST_WIN) begin
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_last ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_ff <= col_ff + ColBits'(1);
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_BIAS && req_table_index < 9'(OutChannels))
         bias_ff[req_table_index[3:0]] <= req_table_value;
      if (accept) begin
         pix_ff <= {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
      end
      if (state_ff == ST_RD1) top_ff <= line_rd;
      if (state_ff == ST_WIN) begin
         for (int y = 0; y < KernelSize; y++)
            for (int x = 0; x < KernelSize - 1; x++)
               win_ff[y][x] <= win_ff[y][x+1];
         win_ff[0][2] <= line_rd;
         win_ff[1][2] <= top_ff;
         win_ff[2][2] <= pix_ff;
         last_frame_ff <= col_last && row_last;
         oc_ff  <= '0;
         tap_ff <= '0;
      end
      if (state_ff == ST_TAP) begin
         if (tap_ff == 5'd0) acc_ff <= 44'(bias_ff[oc_ff]);
         tap_ff <= (tap_ff == 5'(Taps - 1)) ? 5'd0 : tap_ff + 5'd1;
      end
      if (tap_v_ff) acc_ff <= acc_ff + 44'(tap_pix * $signed(w_rd));
      if (state_ff == ST_LEAK)
         act_ff <= (leaky_ff && acc_ff[43]) ? leak_v : acc_ff;
      if (state_ff == ST_MUL) prod_lo_ff <= 64'(mul_part);
      if (state_ff == ST_MULH) prod_ff <= prod_lo_ff + (64'(mul_part) <<< 22);
      if (state_ff == ST_RND) begin
         lane_ff[oc_ff[1:0]] <= sat;
         if (oc_ff[1:0] != 2'(Lanes - 1)) oc_ff <= oc_ff + 4'd1;
      end
      if (state_ff == ST_OUT && (!out_valid_ff || rsp_ready)) begin
         out_word_ff  <= {sat, lane_ff[2], lane_ff[1], lane_ff[0]};
         out_group_ff <= oc_ff[3:2];
         out_lastp_ff <= (oc_ff[3:2] == 2'(Groups - 1));
         out_lastf_ff <= (oc_ff[3:2] == 2'(Groups - 1)) && last_frame_ff;
         oc_ff        <= oc_ff + 4'd1;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_packed_word      = out_word_ff;
   assign rsp_channel_group    = out_group_ff;
   assign rsp_last_of_position = out_lastp_ff;
   assign rsp_last_of_frame    = out_lastf_ff;
endmodule

[tb/sv/conv3x3_checker.sv]
`timescale 1ns / 1ps
// Checker for conv3x3_int8_requant_leaky: watches the config, input and output
// channels, predicts the packed words and compares them. Depends on c3q_pkg.
module conv3x3_checker
   import c3q_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_table_index,
   input  logic [31:0] req_table_value,
   input  logic [7:0]  req_pixel_ch0,
   input  logic [7:0]  req_pixel_ch1,
   input  logic [7:0]  req_pixel_ch2,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_packed_word,
   input  logic [1:0]  rsp_channel_group,
   input  logic        rsp_last_of_position,
   input  logic        rsp_last_of_frame,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          words_pending
);
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  group;
      logic        last_pos;
      logic        last_frame;
   } out_word_type;

   out_word_type expected_words[$];

   logic [9:0]         cfg_width;
   logic [15:0]        cfg_height;
   logic signed [31:0] cfg_mult;
   logic [5:0]         cfg_shift;
   logic               cfg_leaky;

   logic [23:0]        line_mem[2][MaxWidth];
   logic [23:0]        window[3][3];
   logic signed [7:0]  weights[WeightCount];
   logic signed [31:0] biases[OutChannels];
   int                 col_cnt, row_cnt;

   assign words_pending = expected_words.size();

   function automatic longint round_away(longint x, int s);
      logic [63:0] mag;
      if (s == 0) return x;
      mag = (x < 0) ? -x : x;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (x < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [7:0] requantize(longint acc);
      longint v;
      v = acc;
      if (cfg_leaky && acc < 0) v = round_away(acc * 13, 7);
      v = round_away(v * longint'(cfg_mult), int'(cfg_shift));
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return v[7:0];
   endfunction

   task automatic accept_pixel(logic [23:0] pix);
      int w, h, c, r, oc;
      longint acc;
      out_word_type ow;
      w = (cfg_width > MaxWidth) ? MaxWidth : int'(cfg_width);
      h = int'(cfg_height);
      c = col_cnt % MaxWidth;
      r = row_cnt;
      for (int ky = 0; ky < 3; ky++) begin
         window[ky][0] = window[ky][1];
         window[ky][1] = window[ky][2];
      end
      window[0][2] = line_mem[0][c];
      window[1][2] = line_mem[1][c];
      window[2][2] = pix;
      line_mem[0][c] = line_mem[1][c];
      line_mem[1][c] = pix;
      if (c >= 2 && r >= 2) begin
         for (int g = 0; g < Groups; g++) begin
            ow = '0;
            for (int lane = 0; lane < Lanes; lane++) begin
               oc = g * Lanes + lane;
               acc = longint'(biases[oc]);
               for (int ic = 0; ic < InChannels; ic++)
                  for (int ky = 0; ky < 3; ky++)
                     for (int kx = 0; kx < 3; kx++)
                        acc += longint'($signed(window[ky][kx][8*ic +: 8]))
                             * longint'(weights[((oc * 3 + ic) * 3 + ky) * 3 + kx]);
               ow.word[8*lane +: 8] = requantize(acc);
            end
            ow.group      = g[1:0];
            ow.last_pos   = (g == Groups - 1);
            ow.last_frame = (g == Groups - 1) && (c + 1 >= w) && (r + 1 >= h);
            expected_words.push_back(ow);
         end
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_cnt = c + 1;
      end
   endtask

   always @(posedge clock) begin
      out_word_type exp_w;
      if (reset) begin
         cfg_width  <= 10'd64;
         cfg_height <= 16'd64;
         cfg_mult   <= 32'sd1;
         cfg_shift  <= '0;
         cfg_leaky  <= 1'b0;
         col_cnt = 0;
         row_cnt = 0;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH:  cfg_width  <= csr_data[9:0];
               REG_HEIGHT: cfg_height <= csr_data[15:0];
               REG_MULT:   cfg_mult   <= csr_data;
               REG_SHIFT:  cfg_shift  <= csr_data[5:0];
               REG_LEAKY:  cfg_leaky  <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_operation)
               OP_WEIGHT: if (req_table_index < WeightCount)
                  weights[req_table_index] = req_table_value[7:0];
               OP_BIAS: if (req_table_index < OutChannels)
                  biases[req_table_index[3:0]] = req_table_value;
               OP_PIXEL: accept_pixel({req_pixel_ch2, req_pixel_ch1, req_pixel_ch0});
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected word %h group %0d", rsp_packed_word, rsp_channel_group);
            end else begin
               exp_w = expected_words.pop_front();
               if (exp_w.word !== rsp_packed_word || exp_w.group !== rsp_channel_group ||
                   exp_w.last_pos !== rsp_last_of_position ||
                   exp_w.last_frame !== rsp_last_of_frame) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %h g%0d lp%0d lf%0d, got %h g%0d lp%0d lf%0d",
                              exp_w.word, exp_w.group, exp_w.last_pos, exp_w.last_frame,
                              rsp_packed_word, rsp_channel_group, rsp_last_of_position,
                              rsp_last_of_frame);
               end
            end
         end
      end
   end
endmodule

[tb/sv/tb_conv3x3_int8_requant_leaky.sv]
`timescale 1ns / 1ps
// Top of the convolution testbench: clock, reset, stimulus and verdict.
// Depends on c3q_pkg, conv3x3_int8_requant_leaky and conv3x3_checker.
module tb_conv3x3_int8_requant_leaky;
   import c3q_pkg::*;

   localparam int  DrainCycles = 800;
   localparam int  CycleLimit  = 4000000;
   localparam logic [2:0] RegUnused = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_NONE;
   logic [8:0]  req_table_index = '0;
   logic [31:0] req_table_value = '0;
   logic [7:0]  req_pixel_ch0 = '0, req_pixel_ch1 = '0, req_pixel_ch2 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_packed_word;
   logic [1:0]  rsp_channel_group;
   logic        rsp_last_of_position, rsp_last_of_frame;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int  fail_count, words_pending, cycles = 0, items_sent = 0;
   int  send_idle = 25, recv_idle = 83;
   logic req_fire = 1'b0, csr_fire = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   conv3x3_int8_requant_leaky u_dut (.*);

   conv3x3_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_table_index,
      .req_table_value, .req_pixel_ch0, .req_pixel_ch1, .req_pixel_ch2,
      .rsp_valid, .rsp_ready, .rsp_packed_word, .rsp_channel_group,
      .rsp_last_of_position, .rsp_last_of_frame, .csr_valid, .csr_ready,
      .csr_index, .csr_data, .fail_count, .words_pending
   );

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      csr_fire <= csr_valid && csr_ready;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_word(logic [1:0] op, logic [8:0] idx, logic [31:0] val,
                            logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_pixel_ch0   <= p0;
      req_pixel_ch1   <= p1;
      req_pixel_ch2   <= p2;
      do @(negedge clock); while (!req_fire);
   endtask

   // hold until every expected word has come, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [9:0] w, logic [15:0] h, logic [31:0] m,
                            logic [5:0] s, logic lk);
      drain();
      csr_write(REG_WIDTH, {22'($urandom), w});
      csr_write(REG_HEIGHT, {16'($urandom), h});
      csr_write(REG_MULT, m);
      csr_write(REG_SHIFT, {$urandom} & 32'hFFFF_FFC0 | s);
      csr_write(REG_LEAKY, {$urandom} & 32'hFFFF_FFFE | lk);
   endtask

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(7))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_noise();
      case ($urandom_range(2))
         0: send_word(OP_NONE, 9'($urandom_range(511)), $urandom, 8'($urandom),
                      8'($urandom), 8'($urandom));
         1: send_word(OP_WEIGHT, 9'($urandom_range(511, WeightCount)), $urandom,
                      '0, '0, '0);
         default: send_word(OP_BIAS, 9'($urandom_range(511, OutChannels)), $urandom,
                            '0, '0, '0);
      endcase
   endtask

   task automatic feed_pixels(int count, int noise_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < noise_pct) send_noise();
         send_word(OP_PIXEL, 9'($urandom), $urandom, rand_sample(), rand_sample(),
                   rand_sample());
         items_sent++;
      end
   endtask

   task automatic load_tables(int extreme);
      logic [31:0] v;
      for (int i = 0; i < WeightCount; i++) begin
         v = $urandom;
         if (extreme != 0) v[7:0] = (i % 2 == 0) ? 8'h80 : 8'h7F;
         send_word(OP_WEIGHT, 9'(i), v, '0, '0, '0);
      end
      for (int i = 0; i < OutChannels; i++) begin
         case ($urandom_range(3))
            0: v = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: v = $urandom;
            default: v = $signed($urandom_range(20000)) - 10000;
         endcase
         send_word(OP_BIAS, 9'(i), v, '0, '0, '0);
      end
   endtask

   function automatic logic [31:0] rand_mult();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $signed($urandom_range(4000)) - 2000;
      endcase
   endfunction

   initial begin
      int w, h;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: extreme tables and samples, ignored words, degenerate sizes
      load_tables(1);
      configure(10'd3, 16'd3, 32'd1, 6'd0, 1'b0);
      feed_pixels(9, 0);
      configure(10'd3, 16'd3, 32'hFFFF_FFFF, 6'd48, 1'b1);
      send_word(OP_NONE, 9'd0, 32'h0, 8'h7F, 8'h80, 8'h55);
      send_word(OP_WEIGHT, 9'd432, 32'h7F, '0, '0, '0);
      send_word(OP_BIAS, 9'd16, 32'h1234, '0, '0, '0);
      feed_pixels(9, 0);
      configure(10'd2, 16'd2, 32'd7, 6'd63, 1'b1);
      feed_pixels(4, 0);
      configure(10'd0, 16'd0, 32'd7, 6'd1, 1'b0);
      feed_pixels(1, 0);
      csr_write(RegUnused, $urandom);
      csr_write(REG_LEAKY + 3'd1, $urandom);
      load_tables(0);

      // height extreme, then shrink it mid-frame so the rows wrap early
      configure(10'd3, 16'hFFFF, 32'd300, 6'd10, 1'b1);
      feed_pixels(15, 0);
      configure(10'd3, 16'd3, 32'd300, 6'd10, 1'b1);
      feed_pixels(3, 0);

      // random frames under three idle profiles
      while (items_sent < 350) begin
         if (items_sent < 140) begin
            send_idle = 25; recv_idle = 83;
         end else if (items_sent < 260) begin
            send_idle = 83; recv_idle = 25;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         if ($urandom_range(3) == 0) load_tables(0);
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 3) : $urandom_range(8, 3);
         h = $urandom_range(5, 3);
         configure(10'(w), 16'(h), rand_mult(),
                   ($urandom_range(2) == 0) ? 6'($urandom_range(63))
                   : 6'($urandom_range(20, 6)), 1'($urandom_range(1)));
         feed_pixels(w * h, 10);
      end

      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
